>>> design/sd_spi_card_init_assert.svh
// Assertion macros for the checker file of the SD card SPI init sequencer.
`ifndef SD_SPI_CARD_INIT_ASSERT_SVH
`define SD_SPI_CARD_INIT_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define SDINIT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sd_spi_card_init assertion failed");

// Checks that cons holds in the cycle after ante.
`define SDINIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sd_spi_card_init assertion failed");

`endif

>>> design/sdinit_pkg.sv
// Types and constants shared by the SD card SPI init sequencer modules.
package sdinit_pkg;

    localparam int unsigned TIMEOUT_W = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] rx_byte;
    } t_op;

    typedef struct packed {
        logic       valid;
        t_op        op;
    } t_op_link;

endpackage

>>> design/sdinit_if.sv
// Channel interfaces for the request and result beats of the SD card SPI init sequencer.
interface sdinit_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sdinit_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_low;
    logic       done_res;
    logic       success;
    logic [1:0] card_type;
    logic [2:0] error_code;

    modport source (output valid, output tx_valid, output tx_byte, output cs_low,
                    output done_res, output success, output card_type,
                    output error_code, input ready);
    modport sink (input valid, input tx_valid, input tx_byte, input cs_low,
                  input done_res, input success, input card_type,
                  input error_code, output ready);
endinterface

>>> design/sd_spi_card_init.sv
// Top level of the SD card SPI-mode init sequencer.
// Every request beat (start, exchanged byte, millisecond tick) yields exactly one result beat
// that names the next byte to shift out, the chip-select level and the init outcome. The block
// takes one request per cycle while the queue is not full: a classifier feeds a queue of
// QUEUE_DEPTH entries, and the sequencer drains one entry per cycle into a result register
// while the result side is not stalled; each request passes through a queue entry, then the
// result register. Next-state decisions are combinational; the queue absorbs result stalls
// until full. The init timeout register may only be written while no request is outstanding.
module sd_spi_card_init #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sdinit_pkg::TIMEOUT_W-1:0] i_cfg_data,
    sdinit_in_if.sink                        i_req,
    sdinit_out_if.source                     o_res
);

    sdinit_pkg::t_op_link w_link;
    logic                 w_pop;

    sdinit_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_link  (w_link),
        .i_pop   (w_pop)
    );

    sdinit_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_link     (w_link),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule

>>> design/sdinit_front.sv
// Front end: classifies request beats into operations and queues them for the sequencer.
module sdinit_front #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sdinit_in_if.sink            i_req,
    output sdinit_pkg::t_op_link o_link,
    input  logic                 i_pop
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    sdinit_pkg::t_op r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    sdinit_pkg::t_op  w_op;
    logic             w_push;

    always_comb begin
        w_op.rx_byte = i_req.rx_byte;
        unique case (i_req.req_type)
            sdinit_pkg::REQ_START: w_op.code = sdinit_pkg::OP_START;
            sdinit_pkg::REQ_BYTE:  w_op.code = sdinit_pkg::OP_BYTE;
            sdinit_pkg::REQ_TICK:  w_op.code = sdinit_pkg::OP_TICK;
            default:               w_op.code = sdinit_pkg::OP_NONE;
        endcase
    end

    assign i_req.ready = (r_count != CNT_FULL);
    assign w_push      = i_req.valid && i_req.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_op;
        end
    end

    assign o_link.valid = (r_count != '0);
    assign o_link.op    = r_q[r_rd_ptr];

endmodule

>>> design/sdinit_back.sv
// Back end: the init sequencer that carries out queued operations and registers each result.
module sdinit_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sdinit_pkg::TIMEOUT_W-1:0]     i_cfg_data,
    input  sdinit_pkg::t_op_link                 i_link,
    output logic                                 o_pop,
    sdinit_out_if.source                         o_res
);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_PRE        = 4'd1;
    localparam logic [3:0] PH_BUSY       = 4'd2;
    localparam logic [3:0] PH_SEND       = 4'd3;
    localparam logic [3:0] PH_RESP       = 4'd4;
    localparam logic [3:0] PH_R7         = 4'd5;
    localparam logic [3:0] PH_OCR        = 4'd6;
    localparam logic [3:0] PH_OK         = 4'd7;
    localparam logic [3:0] PH_ERR_CMD0   = 4'd8;
    localparam logic [3:0] PH_ERR_CMD8   = 4'd9;
    localparam logic [3:0] PH_ERR_ACMD41 = 4'd10;
    localparam logic [3:0] PH_ERR_CMD58  = 4'd11;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] CMD_SEND_OP   = 6'd41;
    localparam logic [5:0] CMD_READ_OCR  = 6'd58;

    localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
    localparam logic [7:0]  CRC_CMD0     = 8'h95;
    localparam logic [7:0]  CRC_CMD8     = 8'h87;
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;
    localparam logic [7:0]  ECHO_PATTERN = 8'hAA;
    localparam logic [7:0]  R1_IDLE      = 8'h01;
    localparam logic [8:0]  BUSY_LIMIT   = 9'd300;

    localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [1:0] TYPE_SD1     = 2'd1;
    localparam logic [1:0] TYPE_SD2     = 2'd2;
    localparam logic [1:0] TYPE_SDHC    = 2'd3;

    logic [sdinit_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [3:0]  r_phase,   n_phase;
    logic [3:0]  r_cnt,     n_cnt;
    logic [7:0]  r_poll,    n_poll;
    logic [15:0] r_elapsed, n_elapsed;
    logic [8:0]  r_busy,    n_busy;
    logic [5:0]  r_cmd,     n_cmd;
    logic [31:0] r_arg,     n_arg;
    logic [1:0]  r_det,     n_det;

    logic        r_out_valid;
    logic        r_tx_valid, n_tx_valid;
    logic [7:0]  r_tx_byte,  n_tx_byte;
    logic        r_cs_low,   n_cs_low;
    logic        r_done,     n_done;
    logic        r_success,  n_success;
    logic [2:0]  r_err,      n_err;

    logic        w_begin;
    logic [5:0]  w_begin_cmd;
    logic [31:0] w_begin_arg;
    logic [3:0]  w_cnt_inc;
    logic [7:0]  w_rx;
    logic [7:0]  w_send;
    logic [3:0]  w_err_ofs;
    logic        w_running;

    assign o_pop = i_link.valid && (!r_out_valid || o_res.ready);
    assign w_rx = i_link.op.rx_byte;
    assign w_cnt_inc = r_cnt + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_poll      = r_poll;
        n_elapsed   = r_elapsed;
        n_busy      = r_busy;
        n_cmd       = r_cmd;
        n_arg       = r_arg;
        n_det       = r_det;
        w_begin     = 1'b0;
        w_begin_cmd = CMD_GO_IDLE;
        w_begin_arg = '0;
        case (i_link.op.code)
            sdinit_pkg::OP_START: begin
                n_phase   = PH_PRE;
                n_cnt     = '0;
                n_poll    = '0;
                n_elapsed = '0;
                n_busy    = '0;
                n_cmd     = CMD_GO_IDLE;
                n_arg     = '0;
                n_det     = TYPE_UNKNOWN;
            end
            sdinit_pkg::OP_TICK: begin
                if (r_phase >= PH_PRE && r_phase <= PH_OCR) begin
                    if (r_elapsed != 16'hFFFF) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    if (r_busy != 9'h1FF) begin
                        n_busy = r_busy + 1'b1;
                    end
                end
            end
            sdinit_pkg::OP_BYTE: begin
                unique case (r_phase)
                    PH_PRE: begin
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= 4'd10) begin
                            n_cnt   = '0;
                            w_begin = 1'b1;
                        end
                    end
                    PH_BUSY: begin
                        if (w_rx == FILL_BYTE || r_busy >= BUSY_LIMIT) begin
                            n_cnt   = '0;
                            n_phase = PH_SEND;
                        end
                    end
                    PH_SEND: begin
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= 4'd6) begin
                            n_cnt   = '0;
                            n_poll  = '0;
                            n_phase = PH_RESP;
                        end
                    end
                    PH_RESP: begin
                        if (w_rx[7] && r_poll != 8'hFF) begin
                            n_poll = r_poll + 1'b1;
                        end else begin
                            unique case (r_cmd)
                                CMD_GO_IDLE: begin
                                    if (w_rx == R1_IDLE) begin
                                        w_begin     = 1'b1;
                                        w_begin_cmd = CMD_IF_COND;
                                        w_begin_arg = ARG_IF_COND;
                                    end else if (r_elapsed > r_timeout) begin
                                        n_phase = PH_ERR_CMD0;
                                    end else begin
                                        w_begin = 1'b1;
                                    end
                                end
                                CMD_IF_COND: begin
                                    if (w_rx[2]) begin
                                        n_det       = TYPE_SD1;
                                        w_begin     = 1'b1;
                                        w_begin_cmd = CMD_APP;
                                    end else begin
                                        n_cnt   = '0;
                                        n_phase = PH_R7;
                                    end
                                end
                                CMD_APP: begin
                                    w_begin     = 1'b1;
                                    w_begin_cmd = CMD_SEND_OP;
                                    w_begin_arg = (r_det == TYPE_SD2) ? ARG_HCS : '0;
                                end
                                CMD_SEND_OP: begin
                                    if (w_rx == 8'h00) begin
                                        if (r_det == TYPE_SD2) begin
                                            w_begin     = 1'b1;
                                            w_begin_cmd = CMD_READ_OCR;
                                        end else begin
                                            n_phase = PH_OK;
                                        end
                                    end else if (r_elapsed > r_timeout) begin
                                        n_phase = PH_ERR_ACMD41;
                                    end else begin
                                        w_begin     = 1'b1;
                                        w_begin_cmd = CMD_APP;
                                    end
                                end
                                default: begin
                                    if (w_rx != 8'h00) begin
                                        n_phase = PH_ERR_CMD58;
                                    end else begin
                                        n_cnt   = '0;
                                        n_phase = PH_OCR;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_R7: begin
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= 4'd4) begin
                            n_cnt = '0;
                            if (w_rx == ECHO_PATTERN) begin
                                n_det       = TYPE_SD2;
                                w_begin     = 1'b1;
                                w_begin_cmd = CMD_APP;
                            end else begin
                                n_phase = PH_ERR_CMD8;
                            end
                        end
                    end
                    PH_OCR: begin
                        if (r_cnt == '0 && w_rx[7:6] == 2'b11) begin
                            n_det = TYPE_SDHC;
                        end
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= 4'd4) begin
                            n_cnt   = '0;
                            n_phase = PH_OK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        if (w_begin) begin
            n_cmd   = w_begin_cmd;
            n_arg   = w_begin_arg;
            n_busy  = '0;
            n_phase = PH_BUSY;
        end
    end

    always_comb begin
        case (n_cnt)
            4'd0:    w_send = {2'b01, n_cmd};
            4'd1:    w_send = n_arg[31:24];
            4'd2:    w_send = n_arg[23:16];
            4'd3:    w_send = n_arg[15:8];
            4'd4:    w_send = n_arg[7:0];
            default: begin
                if (n_cmd == CMD_GO_IDLE) begin
                    w_send = CRC_CMD0;
                end else if (n_cmd == CMD_IF_COND) begin
                    w_send = CRC_CMD8;
                end else begin
                    w_send = FILL_BYTE;
                end
            end
        endcase
        w_running  = (n_phase >= PH_PRE) && (n_phase <= PH_OCR);
        w_err_ofs  = n_phase - PH_OK;
        n_tx_valid = w_running;
        n_tx_byte  = !w_running ? 8'h00 : ((n_phase == PH_SEND) ? w_send : FILL_BYTE);
        n_cs_low   = w_running && (n_phase != PH_PRE);
        n_done     = (n_phase >= PH_OK);
        n_success  = (n_phase == PH_OK);
        n_err      = (n_phase > PH_OK) ? w_err_ofs[2:0] : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= sdinit_pkg::TIMEOUT_RESET;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_poll      <= '0;
            r_elapsed   <= '0;
            r_busy      <= '0;
            r_cmd       <= CMD_GO_IDLE;
            r_arg       <= '0;
            r_det       <= TYPE_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (o_pop) begin
                r_phase   <= n_phase;
                r_cnt     <= n_cnt;
                r_poll    <= n_poll;
                r_elapsed <= n_elapsed;
                r_busy    <= n_busy;
                r_cmd     <= n_cmd;
                r_arg     <= n_arg;
                r_det     <= n_det;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
            r_cs_low   <= n_cs_low;
            r_done     <= n_done;
            r_success  <= n_success;
            r_err      <= n_err;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.tx_valid   = r_tx_valid;
    assign o_res.tx_byte    = r_tx_byte;
    assign o_res.cs_low     = r_cs_low;
    assign o_res.done_res   = r_done;
    assign o_res.success    = r_success;
    assign o_res.card_type  = r_det;
    assign o_res.error_code = r_err;

endmodule

>>> design/sdinit_chk.sv
// Port-level checker for the SD card SPI init sequencer and its bind to the top level.
`include "sd_spi_card_init_assert.svh"

module sdinit_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_tx_valid,
    input logic [7:0] i_tx_byte,
    input logic       i_cs_low,
    input logic       i_done_res,
    input logic       i_success,
    input logic [2:0] i_error_code
);

    `SDINIT_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_tx_byte) && $stable(i_done_res) && $stable(i_error_code))
    `SDINIT_ASSERT_SAME(a_success_clean, i_clk, i_rst_n, i_out_valid && i_success, i_done_res && (i_error_code == 3'd0))
    `SDINIT_ASSERT_SAME(a_error_done, i_clk, i_rst_n, i_out_valid && (i_error_code != 3'd0), i_done_res && !i_success && !i_cs_low)
    `SDINIT_ASSERT_SAME(a_idle_quiet, i_clk, i_rst_n, i_out_valid && !i_tx_valid, (i_tx_byte == 8'h00) && !i_cs_low)

endmodule

bind sd_spi_card_init sdinit_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_tx_valid   (o_res.tx_valid),
    .i_tx_byte    (o_res.tx_byte),
    .i_cs_low     (o_res.cs_low),
    .i_done_res   (o_res.done_res),
    .i_success    (o_res.success),
    .i_error_code (o_res.error_code)
);
